// ===== rtl/rcm_pkg.sv =====
package rcm_pkg;

  // One input word.
  typedef struct packed {
    logic        operation;
    logic [10:0] range_lo;
    logic [10:0] range_hi;
    logic [30:0] value;
  } rcm_in_t;

  // One result word.
  typedef struct packed {
    logic [30:0] min_value;
    logic        empty_range;
  } rcm_out_t;

  localparam logic OP_RAISE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } rcm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic sweep;
  } rcm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic load_empty;
    logic sweep_end;
  } rcm_status_t;

endpackage

// ===== rtl/rcm_ctrl.sv =====
module rcm_ctrl
  import rcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  rcm_status_t status,
  output rcm_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  rcm_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = status.load_empty ? ST_DONE : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (status.sweep_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/rcm_dp.sv =====
module rcm_dp
  import rcm_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rcm_in_t     in_data,
  input  rcm_cmd_t    cmd,
  output rcm_status_t status,
  output rcm_out_t    out_data
);

  localparam int AW = $clog2(LEAVES);

  logic [30:0] mem [LEAVES];

  logic [AW:0]   clr_r;
  logic [AW:0]   addr_r;
  logic [AW:0]   hi_r;
  logic [AW-1:0] rd_addr_r;
  logic          rd_valid_r;
  logic [30:0]   rdata_r;
  logic          op_r;
  logic          empty_r;
  logic [30:0]   val_r;
  logic [30:0]   acc_r;

  logic [31:0] lo_w, hi_w;
  logic [AW:0] lo_c, hi_c;
  logic        issue;

  // Clamp the range to the number of positions.
  assign lo_w = 32'(in_data.range_lo);
  assign hi_w = 32'(in_data.range_hi);
  assign lo_c = (AW+1)'((lo_w > 32'(LEAVES)) ? 32'(LEAVES) : lo_w);
  assign hi_c = (AW+1)'((hi_w > 32'(LEAVES)) ? 32'(LEAVES) : hi_w);

  assign issue = cmd.sweep && (addr_r != hi_r);

  assign status.clear_last = (clr_r == (AW+1)'(LEAVES - 1));
  assign status.load_empty = (lo_c >= hi_c);
  assign status.sweep_end  = (addr_r == hi_r) && !rd_valid_r;

  // Clearing counter after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // Read pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= issue;
    end
  end

  // Memory: one read and one write a cycle.
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_r[AW-1:0]] <= '0;
    end else if (rd_valid_r && op_r == OP_RAISE) begin
      mem[rd_addr_r] <= (rdata_r > val_r) ? rdata_r : val_r;
    end
    rdata_r <= mem[addr_r[AW-1:0]];
  end

  // Operation registers, sweep address and running minimum.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.operation;
      val_r   <= in_data.value;
      addr_r  <= lo_c;
      hi_r    <= hi_c;
      empty_r <= (lo_c >= hi_c);
      acc_r   <= VAL_MAX;
    end else begin
      if (issue) begin
        addr_r <= addr_r + 1'b1;
      end
      if (rd_valid_r && rdata_r < acc_r) begin
        acc_r <= rdata_r;
      end
    end
    rd_addr_r <= addr_r[AW-1:0];
  end

  // Result word.
  always_comb begin
    out_data = '0;
    if (op_r == OP_QUERY) begin
      if (empty_r) begin
        out_data.empty_range = 1'b1;
      end else begin
        out_data.min_value = acc_r;
      end
    end
  end

endmodule

// ===== rtl/range_chmax_range_min_tree_top.sv =====
// Range raise and range minimum over LEAVES positions.
// Input channel: present a word on in_data and raise start; it is taken at a
// rising edge where start is high and busy is low. Operation raise lifts every
// position of the half-open range to at least value; operation query returns
// the minimum over the range. Range bounds are clamped to LEAVES.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver must take it then. A raise returns zero; an empty query range
// returns empty_range set and min_value zero.
// Sweep: the positions of the range are read in turn from the leaf memory,
// which takes one read and one write a cycle; an empty range skips the sweep.
// busy is high while an operation runs and one operation is in flight at a
// time. The next word can be taken once busy is low again after the result cycle.
// Reset: synchronous, active low. A clearing pass zeroes every position of the
// leaf memory, with busy high, before the first word is taken.
module range_chmax_range_min_tree_top
  import rcm_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  rcm_in_t  in_data,
  output logic     busy,
  output logic     out_valid,
  output rcm_out_t out_data
);

  rcm_cmd_t    cmd;
  rcm_status_t status;

  // Sequencer.
  rcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Leaf memory and sweep datapath.
  rcm_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== tb/range_chmax_range_min_tree_top_tb.sv =====
`timescale 1ns / 100ps

module range_chmax_range_min_tree_top_tb;
  import rcm_pkg::*;

  localparam int LEAVES    = 1024;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = LEAVES + 20;

  logic     clk;
  logic     rst_n;
  logic     start;
  rcm_in_t  in_data;
  logic     busy;
  logic     out_valid;
  rcm_out_t out_data;

  // Flat model of the positions; a lazy tree gives the same answers.
  logic [30:0] level_q [LEAVES];
  // Expected results in order, as a small ring.
  rcm_out_t    exp_mem [16];
  int          exp_push_cnt;
  int          exp_pop_cnt;
  int          err_cnt;
  int          word_cnt;
  int          query_cnt;
  int          result_cnt;
  int          quiet_cyc;
  bit          allow_gaps;

  range_chmax_range_min_tree_top #(.LEAVES(LEAVES)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Clock generation.
  always #10 clk = ~clk;

  // Work out the result of one word and apply it to the level model.
  function automatic rcm_out_t apply_range_word(rcm_in_t w);
    rcm_out_t    r;
    int          lo;
    int          hi;
    logic [30:0] m;
    lo = (w.range_lo > LEAVES) ? LEAVES : int'(w.range_lo);
    hi = (w.range_hi > LEAVES) ? LEAVES : int'(w.range_hi);
    r = '0;
    if (w.operation == OP_RAISE) begin
      for (int i = lo; i < hi; i++) begin
        if (level_q[i] < w.value) level_q[i] = w.value;
      end
    end else if (lo < hi) begin
      m = VAL_MAX;
      for (int i = lo; i < hi; i++) begin
        if (level_q[i] < m) m = level_q[i];
      end
      r.min_value = m;
    end else begin
      r.empty_range = 1'b1;
    end
    return r;
  endfunction

  // Send one word, with an optional random gap before it. Start stays high
  // after a word is taken; busy holds the next one off until the block is free.
  task automatic send_word(logic op, int lo, int hi, logic [30:0] val);
    rcm_in_t w;
    w.operation = op;
    w.range_lo  = lo[10:0];
    w.range_hi  = hi[10:0];
    w.value     = val;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    exp_mem[exp_push_cnt[3:0]] = apply_range_word(w);
    exp_push_cnt++;
    word_cnt++;
    if (op == OP_QUERY) query_cnt++;
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    rcm_out_t exp_r;
    if (rst_n && out_valid) begin
      result_cnt++;
      if (exp_push_cnt == exp_pop_cnt) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_data);
        err_cnt++;
      end else begin
        exp_r = exp_mem[exp_pop_cnt[3:0]];
        exp_pop_cnt++;
        if (out_data.min_value !== exp_r.min_value) begin
          $display("%0t: min_value expected %h actual %h", $time,
                   exp_r.min_value, out_data.min_value);
          err_cnt++;
        end
        if (out_data.empty_range !== exp_r.empty_range) begin
          $display("%0t: empty_range expected %b actual %b", $time,
                   exp_r.empty_range, out_data.empty_range);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WDOG_MAX) begin
      $display("range_chmax_range_min_tree_top_tb: done, errors");
      $finish;
    end
  end

  // Short random ranges mostly, with a few wide ones.
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return $urandom_range(0, 16);
    if (sel < 18) return $urandom_range(0, 128);
    return $urandom_range(0, LEAVES);
  endfunction

  function automatic logic [30:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 15));
      1: return VAL_MAX - 31'($urandom_range(0, 15));
      default: return 31'($urandom()) & VAL_MAX;
    endcase
  endfunction

  task automatic test_directed_edges();
    send_word(OP_QUERY, 0, LEAVES, 31'h1234);
    send_word(OP_RAISE, 0, 1, VAL_MAX);
    send_word(OP_QUERY, 0, 1, '0);
    send_word(OP_QUERY, 0, 2, '0);
    send_word(OP_RAISE, LEAVES - 1, LEAVES, 31'h5555_5555);
    send_word(OP_QUERY, LEAVES - 1, LEAVES, '0);
    send_word(OP_RAISE, 100, 200, 31'd7);
    send_word(OP_RAISE, 150, 250, 31'd3);
    send_word(OP_QUERY, 100, 250, '0);
    send_word(OP_QUERY, 201, 250, '0);
    // Bounds beyond the end are clamped.
    send_word(OP_RAISE, 1000, 2047, 31'd9);
    send_word(OP_QUERY, 1010, 2047, '0);
    send_word(OP_QUERY, 2047, 2047, '0);
    send_word(OP_QUERY, 1024, 2000, '0);
    // Empty and reversed ranges.
    send_word(OP_RAISE, 300, 300, VAL_MAX);
    send_word(OP_RAISE, 400, 350, VAL_MAX);
    send_word(OP_QUERY, 300, 301, '0);
    send_word(OP_QUERY, 500, 499, '0);
    send_word(OP_QUERY, 5, 5, '0);
    // Raise of zero changes nothing.
    send_word(OP_RAISE, 0, LEAVES, '0);
    send_word(OP_RAISE, 0, LEAVES, 31'd1);
    send_word(OP_QUERY, 0, LEAVES, '0);
  endtask

  task automatic test_random_ops(int n, bit gaps);
    int lo;
    int hi;
    logic op;
    allow_gaps = gaps;
    for (int k = 0; k < n; k++) begin
      op = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 15) == 0) begin
        // Raw field values, out of range and reversed included.
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end else begin
        lo = $urandom_range(0, LEAVES - 1);
        hi = lo + pick_len();
        if (hi > LEAVES) hi = LEAVES;
      end
      send_word(op, lo, hi, pick_value());
    end
  endtask

  initial begin
    int drain;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    err_cnt = 0;
    word_cnt = 0;
    query_cnt = 0;
    result_cnt = 0;
    quiet_cyc = 0;
    exp_push_cnt = 0;
    exp_pop_cnt = 0;
    allow_gaps = 1'b1;
    foreach (level_q[i]) level_q[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_random_ops(650, 1'b1);
    test_random_ops(200, 1'b0);
    start <= 1'b0;

    // Wait for the last results, then a little longer for strays.
    drain = 0;
    while (exp_push_cnt != exp_pop_cnt && drain < WDOG_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d words (%0d queries), got %0d results.",
             word_cnt, query_cnt, result_cnt);
    $display("Covered clamped, empty and reversed ranges and extreme levels.");
    if (err_cnt == 0 && exp_push_cnt == exp_pop_cnt) begin
      $display("range_chmax_range_min_tree_top_tb: done, clean");
    end else begin
      $display("range_chmax_range_min_tree_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== range_chmax_range_min_tree_top.f =====
rtl/rcm_pkg.sv
rtl/rcm_ctrl.sv
rtl/rcm_dp.sv
rtl/range_chmax_range_min_tree_top.sv
tb/range_chmax_range_min_tree_top_tb.sv
